>>> rtl/core/lras_pkg.sv
// Package with shared constants and control types for the range add and sum store.
`timescale 1ns / 1ps
package lras_pkg;

  localparam int LEAVES = 1024;
  localparam int ADDR_W = $clog2(LEAVES);
  localparam int IDX_W = ADDR_W + 2;
  localparam int POS_W = 11;
  localparam int DATA_W = 32;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] IDX_L = 2'd0;
  localparam logic [1:0] IDX_R1 = 2'd1;
  localparam logic [1:0] IDX_R = 2'd2;
  localparam logic [1:0] IDX_LM1 = 2'd3;

  localparam logic [1:0] MUL_D_LM1 = 2'd0;
  localparam logic [1:0] MUL_D_R = 2'd1;
  localparam logic [1:0] MUL_S_LM1 = 2'd2;
  localparam logic [1:0] MUL_S_R = 2'd3;

  typedef struct packed {
    logic load;
    logic clr_start;
    logic clr_step;
    logic idx_set;
    logic [1:0] idx_sel;
    logic mul_en;
    logic [1:0] mul_sel;
    logic vals_set;
    logic neg_vals;
    logic rd;
    logic upd;
    logic acc_clr;
    logic acc_step;
    logic hold_set;
    logic emit;
    logic emit_bad;
  } lras_cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic bad;
    logic idx_zero;
    logic idx_over;
    logic clr_last;
  } lras_stat_t;

endpackage

>>> rtl/core/lras_datapath.sv
// Datapath: two binary indexed tree memories, walk index, accumulators and multiplier.
`timescale 1ns / 1ps
module lras_datapath (
  input  logic clk,
  input  logic rst,
  input  lras_pkg::lras_cmd_t cmd,
  output lras_pkg::lras_stat_t stat,
  input  logic used_size_we,
  input  logic [10:0] used_size,
  input  logic [1:0] opcode,
  input  logic [10:0] range_low,
  input  logic [10:0] range_high,
  input  logic signed [31:0] delta,
  output logic valid,
  output logic signed [31:0] sum,
  output logic bad_range
);
  import lras_pkg::*;

  logic [DATA_W-1:0] mem1 [0:LEAVES-1];
  logic [DATA_W-1:0] mem2 [0:LEAVES-1];
  logic [DATA_W-1:0] rdata1;
  logic [DATA_W-1:0] rdata2;

  logic [POS_W-1:0] size_reg;
  logic [1:0] op_reg;
  logic [POS_W-1:0] l_reg;
  logic [POS_W-1:0] r_reg;
  logic [DATA_W-1:0] d_reg;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx_next;
  logic [IDX_W-1:0] lowbit;
  logic [ADDR_W-1:0] addr;
  logic [ADDR_W-1:0] clr_addr;
  logic [DATA_W-1:0] v1;
  logic [DATA_W-1:0] v2;
  logic [DATA_W-1:0] acc1;
  logic [DATA_W-1:0] acc2;
  logic [DATA_W-1:0] prod;
  logic [DATA_W-1:0] hold;
  logic [DATA_W-1:0] part;
  logic [DATA_W-1:0] mul_a;
  logic [POS_W-1:0] mul_b;
  logic [POS_W-1:0] lm1;
  logic [POS_W-1:0] limit;
  logic [ADDR_W-1:0] wr_addr;
  logic [DATA_W-1:0] wr1;
  logic [DATA_W-1:0] wr2;
  logic wr_en;

  assign lm1 = l_reg - POS_W'(1);
  assign limit = (size_reg > POS_W'(LEAVES)) ? POS_W'(LEAVES) : size_reg;
  assign lowbit = idx & (~idx + IDX_W'(1));
  assign addr = ADDR_W'(idx - IDX_W'(1));
  assign part = prod - acc2;
  assign mul_a = cmd.mul_sel[1] ? acc1 : d_reg;
  assign mul_b = cmd.mul_sel[0] ? r_reg : lm1;

  assign stat.opcode = op_reg;
  assign stat.bad = (l_reg == '0) || (l_reg > r_reg) || (r_reg > limit);
  assign stat.idx_zero = (idx == '0);
  assign stat.idx_over = (idx > IDX_W'(LEAVES));
  assign stat.clr_last = (clr_addr == ADDR_W'(LEAVES - 1));

  always_comb begin
    case (cmd.idx_sel)
      IDX_L: idx_next = IDX_W'(l_reg);
      IDX_R1: idx_next = IDX_W'(r_reg) + IDX_W'(1);
      IDX_R: idx_next = IDX_W'(r_reg);
      default: idx_next = IDX_W'(lm1);
    endcase
  end

  assign wr_en = cmd.clr_step | cmd.upd;
  assign wr_addr = cmd.clr_step ? clr_addr : addr;
  assign wr1 = cmd.clr_step ? '0 : rdata1 + v1;
  assign wr2 = cmd.clr_step ? '0 : rdata2 + v2;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem1[wr_addr] <= wr1;
      mem2[wr_addr] <= wr2;
    end
    if (cmd.rd) begin
      rdata1 <= mem1[addr];
      rdata2 <= mem2[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_reg <= POS_W'(LEAVES);
      valid <= 1'b0;
      clr_addr <= '0;
    end else begin
      if (used_size_we) begin
        size_reg <= used_size;
      end
      valid <= cmd.emit | cmd.emit_bad;
      if (cmd.clr_start) begin
        clr_addr <= '0;
      end else if (cmd.clr_step) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_reg <= opcode;
      l_reg <= range_low;
      r_reg <= range_high;
      d_reg <= delta;
    end
    if (cmd.idx_set) begin
      idx <= idx_next;
    end else if (cmd.upd) begin
      idx <= idx + lowbit;
    end else if (cmd.acc_step) begin
      idx <= idx - lowbit;
    end
    if (cmd.mul_en) begin
      prod <= DATA_W'(mul_a * {{(DATA_W-POS_W){1'b0}}, mul_b});
    end
    if (cmd.vals_set) begin
      v1 <= cmd.neg_vals ? -d_reg : d_reg;
      v2 <= cmd.neg_vals ? -prod : prod;
    end
    if (cmd.acc_clr) begin
      acc1 <= '0;
      acc2 <= '0;
    end else if (cmd.acc_step) begin
      acc1 <= acc1 + rdata1;
      acc2 <= acc2 + rdata2;
    end
    if (cmd.hold_set) begin
      hold <= part;
    end
    if (cmd.emit) begin
      sum <= hold - part;
      bad_range <= 1'b0;
    end else if (cmd.emit_bad) begin
      sum <= '0;
      bad_range <= 1'b1;
    end
  end

endmodule

>>> rtl/core/lras_ctrl.sv
// Controller state machine that sequences tree walks, clears and results.
`timescale 1ns / 1ps
module lras_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  lras_pkg::lras_stat_t stat,
  output lras_pkg::lras_cmd_t cmd
);
  import lras_pkg::*;

  localparam logic [3:0] S_CLR = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_DECODE = 4'd2;
  localparam logic [3:0] S_A_MUL = 4'd3;
  localparam logic [3:0] S_A_VALS = 4'd4;
  localparam logic [3:0] S_U_RD = 4'd5;
  localparam logic [3:0] S_U_WR = 4'd6;
  localparam logic [3:0] S_Q_RD = 4'd7;
  localparam logic [3:0] S_Q_ACC = 4'd8;
  localparam logic [3:0] S_Q_MUL = 4'd9;
  localparam logic [3:0] S_Q_PART = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;
  logic phase;
  logic phase_next;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      phase <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    phase_next = phase;
    case (state)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        phase_next = 1'b0;
        case (stat.opcode)
          OP_ADD: begin
            state_next = stat.bad ? S_IDLE : S_A_MUL;
          end
          OP_QUERY: begin
            if (stat.bad) begin
              cmd.emit_bad = 1'b1;
              state_next = S_IDLE;
            end else begin
              cmd.idx_set = 1'b1;
              cmd.idx_sel = IDX_R;
              cmd.acc_clr = 1'b1;
              state_next = S_Q_RD;
            end
          end
          OP_CLEAR: begin
            cmd.clr_start = 1'b1;
            state_next = S_CLR;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_A_MUL: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = phase ? MUL_D_R : MUL_D_LM1;
        cmd.idx_set = 1'b1;
        cmd.idx_sel = phase ? IDX_R1 : IDX_L;
        state_next = S_A_VALS;
      end
      S_A_VALS: begin
        cmd.vals_set = 1'b1;
        cmd.neg_vals = phase;
        state_next = S_U_RD;
      end
      S_U_RD: begin
        if (stat.idx_over || stat.idx_zero) begin
          phase_next = 1'b1;
          state_next = phase ? S_IDLE : S_A_MUL;
        end else begin
          cmd.rd = 1'b1;
          state_next = S_U_WR;
        end
      end
      S_U_WR: begin
        cmd.upd = 1'b1;
        state_next = S_U_RD;
      end
      S_Q_RD: begin
        if (stat.idx_zero) begin
          state_next = S_Q_MUL;
        end else begin
          cmd.rd = 1'b1;
          state_next = S_Q_ACC;
        end
      end
      S_Q_ACC: begin
        cmd.acc_step = 1'b1;
        state_next = S_Q_RD;
      end
      S_Q_MUL: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = phase ? MUL_S_LM1 : MUL_S_R;
        state_next = S_Q_PART;
      end
      S_Q_PART: begin
        if (phase) begin
          cmd.emit = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.hold_set = 1'b1;
          cmd.idx_set = 1'b1;
          cmd.idx_sel = IDX_LM1;
          cmd.acc_clr = 1'b1;
          phase_next = 1'b1;
          state_next = S_Q_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> rtl/core/lazy_range_add_sum_tree.sv
// Top level of the range add and range sum store.
//
// A word is taken when start is high and busy is low, and the block works on one word at a
// time. Range adds and sums are kept as two binary indexed trees over 1024 positions in
// single-port memories; each tree step is a read and a write (add) or a read and an
// accumulate (query). After a word is taken busy stays high for the decode state and then,
// on an add, for two passes of a multiply, a value setup, up to 11 and then 10 read and
// write pairs, and an end check, or on a query for two passes of up to 10 read and
// accumulate pairs, an end check, a multiply and a subtract. A bad range ends after the
// decode cycle. A clear sweeps the memories one entry a cycle, as does the clearing pass
// after reset. A query result appears for exactly one cycle with valid high, in the cycle
// in which busy falls; the receiver cannot stall it and must take it then.
`timescale 1ns / 1ps
module lazy_range_add_sum_tree (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic used_size_we,
  input  logic [10:0] used_size,
  input  logic [1:0] opcode,
  input  logic [10:0] range_low,
  input  logic [10:0] range_high,
  input  logic signed [31:0] delta,
  output logic valid,
  output logic signed [31:0] sum,
  output logic bad_range
);
  import lras_pkg::*;

  lras_cmd_t cmd;
  lras_stat_t stat;

  lras_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .stat(stat),
    .cmd(cmd)
  );

  lras_datapath u_datapath (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .stat(stat),
    .used_size_we(used_size_we),
    .used_size(used_size),
    .opcode(opcode),
    .range_low(range_low),
    .range_high(range_high),
    .delta(delta),
    .valid(valid),
    .sum(sum),
    .bad_range(bad_range)
  );

endmodule

>>> dv/tb_lazy_range_add_sum_tree.sv
// Testbench for the range add and range sum store, checked against a flat array predictor.
`timescale 1ns / 1ps
module tb_lazy_range_add_sum_tree;
  import lras_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE = 60;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [31:0] total;
    logic flag;
  } answer_t;

  typedef struct {
    logic [1:0] op;
    logic [10:0] lo;
    logic [10:0] hi;
    logic [31:0] amt;
    bit typed;
    logic [31:0] t_sum;
    logic t_bad;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic used_size_we = 0;
  logic [10:0] used_size = 11'd1024;
  logic [1:0] opcode = OP_ADD;
  logic [10:0] range_low = 0;
  logic [10:0] range_high = 0;
  logic signed [31:0] delta = 0;
  logic valid;
  logic signed [31:0] sum;
  logic bad_range;

  logic [31:0] pos_val [1:LEAVES];
  logic [10:0] size_reg;
  answer_t pending_answers[$];
  int errors = 0;
  int words_sent = 0;
  int answers_checked = 0;
  int cycles = 0;
  bit gaps_on = 1;

  lazy_range_add_sum_tree dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .used_size_we(used_size_we), .used_size(used_size),
    .opcode(opcode), .range_low(range_low), .range_high(range_high), .delta(delta),
    .valid(valid), .sum(sum), .bad_range(bad_range)
  );

  initial forever #10 clk = ~clk;

  initial forever begin
    @(posedge clk);
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int lim_now();
    return (size_reg > LEAVES) ? LEAVES : int'(size_reg);
  endfunction

  function automatic bit range_bad(logic [10:0] lo, logic [10:0] hi);
    return (lo == 0) || (lo > hi) || (int'(hi) > lim_now());
  endfunction

  // Applies one word to the predictor and returns 1 when it yields an answer.
  function automatic bit predict_word(logic [1:0] op, logic [10:0] lo, logic [10:0] hi,
                                      logic [31:0] amt, output answer_t ans);
    logic [31:0] acc;
    bit bad;
    acc = 0;
    bad = range_bad(lo, hi);
    ans = '0;
    case (op)
      OP_ADD: begin
        if (!bad) for (int i = lo; i <= hi; i++) pos_val[i] += amt;
        return 0;
      end
      OP_QUERY: begin
        if (!bad) for (int i = lo; i <= hi; i++) acc += pos_val[i];
        ans.total = acc;
        ans.flag = bad;
        return 1;
      end
      OP_CLEAR: begin
        for (int i = 1; i <= LEAVES; i++) pos_val[i] = 0;
        return 0;
      end
      default: return 0;
    endcase
  endfunction

  task automatic send_word(row_t r);
    answer_t ans;
    int gap;
    gap = gaps_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1;
    opcode <= r.op;
    range_low <= r.lo;
    range_high <= r.hi;
    delta <= r.amt;
    do @(posedge clk); while (busy);
    words_sent++;
    if (predict_word(r.op, r.lo, r.hi, r.amt, ans)) begin
      if (r.typed) begin
        ans.total = r.t_sum;
        ans.flag = r.t_bad;
      end
      pending_answers.push_back(ans);
    end
  endtask

  task automatic drain();
    start <= 0;
    do @(posedge clk); while (busy || pending_answers.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_size(logic [10:0] v);
    used_size_we <= 1;
    used_size <= v;
    @(posedge clk);
    used_size_we <= 0;
    size_reg = v;
  endtask

  function automatic row_t rand_row();
    row_t r;
    int pick;
    int lim;
    r = '{default: 0};
    lim = lim_now();
    pick = $urandom_range(0, 99);
    r.op = (pick < 46) ? OP_ADD : (pick < 94) ? OP_QUERY : (pick < 97) ? OP_CLEAR : OP_UNUSED;
    r.amt = $urandom();
    if (lim == 0 || $urandom_range(0, 9) == 0) begin
      r.lo = 11'($urandom_range(0, 2047));
      r.hi = 11'($urandom_range(0, 2047));
    end else begin
      r.lo = 11'($urandom_range(1, lim));
      if ($urandom_range(0, 2) == 0) r.hi = 11'($urandom_range(r.lo, lim));
      else r.hi = 11'($urandom_range(r.lo, (r.lo + 8 > lim) ? lim : r.lo + 8));
    end
    return r;
  endfunction

  always @(posedge clk) begin
    answer_t exp_a;
    if (!rst && valid) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected answer sum=%h bad=%b", $time, sum, bad_range);
        errors++;
      end else begin
        exp_a = pending_answers.pop_front();
        answers_checked++;
        if (sum !== exp_a.total) begin
          $display("%0t: sum expected %h actual %h", $time, exp_a.total, sum);
          errors++;
        end
        if (bad_range !== exp_a.flag) begin
          $display("%0t: bad_range expected %b actual %b", $time, exp_a.flag, bad_range);
          errors++;
        end
      end
    end
  end

  initial begin
    row_t dir [$];
    logic [10:0] sizes [6];
    for (int i = 1; i <= LEAVES; i++) pos_val[i] = 0;
    size_reg = 11'd1024;
    sizes = '{11'd1, 11'd0, 11'd2047, 11'd700, 11'd37, 11'd1024};
    dir = '{
      '{OP_QUERY, 1, 1024, 0, 1, 0, 0},
      '{OP_ADD, 1, 1024, 1, 0, 0, 0},
      '{OP_QUERY, 1, 1024, 0, 0, 0, 0},
      '{OP_QUERY, 0, 5, 0, 1, 0, 1},
      '{OP_QUERY, 5, 4, 0, 1, 0, 1},
      '{OP_QUERY, 1, 1025, 0, 1, 0, 1},
      '{OP_QUERY, 2047, 2047, 0, 1, 0, 1},
      '{OP_ADD, 1, 1, 32'h7fffffff, 0, 0, 0},
      '{OP_ADD, 1024, 1024, 32'h80000000, 0, 0, 0},
      '{OP_QUERY, 1, 1, 0, 0, 0, 0},
      '{OP_QUERY, 1024, 1024, 0, 0, 0, 0},
      '{OP_QUERY, 1, 1024, 0, 0, 0, 0},
      '{OP_ADD, 3, 2, 32'h55, 0, 0, 0},
      '{OP_ADD, 0, 3, 32'haa, 0, 0, 0},
      '{OP_UNUSED, 1, 4, 32'hff, 0, 0, 0},
      '{OP_QUERY, 1, 4, 0, 0, 0, 0},
      '{OP_ADD, 10, 500, 32'hffffffff, 0, 0, 0},
      '{OP_QUERY, 200, 800, 0, 0, 0, 0},
      '{OP_CLEAR, 0, 0, 0, 0, 0, 0},
      '{OP_QUERY, 1, 1024, 0, 1, 0, 0}
    };
    repeat (3) @(posedge clk);
    rst <= 0;
    foreach (dir[i]) send_word(dir[i]);
    drain();
    foreach (sizes[p]) begin
      write_size(sizes[p]);
      for (int n = 0; n < 240; n++) begin
        if (n % 60 == 0) gaps_on = $urandom_range(0, 2) != 0;
        send_word(rand_row());
      end
      drain();
    end
    $display("Sent %0d words over %0d size settings; checked %0d query answers.",
             words_sent, $size(sizes), answers_checked);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

>>> sim.f
rtl/core/lras_pkg.sv
rtl/core/lras_datapath.sv
rtl/core/lras_ctrl.sv
rtl/core/lazy_range_add_sum_tree.sv
dv/tb_lazy_range_add_sum_tree.sv
